FILE: rtl/tamrb_pkg.sv
// tamrb_pkg: shared constants, codes and types for the timed audio mixing ring.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tamrb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 4096;
  localparam int unsigned MAX_FRAME_DEF  = 1024;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 6;

  localparam logic [1:0] OP_TIMED = 2'd0;
  localparam logic [1:0] OP_HEAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LATE = 2'd1;
  localparam logic [1:0] ST_FAR  = 2'd2;
  localparam logic [1:0] ST_DIS  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd4;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tamrb_div.sv
// tamrb_div: shared restoring divider, one quotient bit per cycle.
// Dividend is left aligned by the caller; runs a given number of steps.
// Depends on tamrb_pkg.
`default_nettype none

module tamrb_div #(
  parameter int unsigned DVW = 13
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  tamrb_pkg::div_ctrl_t            ctrl_i,
  input  wire  [tamrb_pkg::TIME_W-1:0]          dividend_i,
  input  wire  [DVW-1:0]                        divisor_i,
  output tamrb_pkg::div_stat_t                  stat_o,
  output logic [tamrb_pkg::TIME_W-1:0]          quot_o,
  output logic [DVW-1:0]                        rem_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [tamrb_pkg::STEP_W-1:0]       cnt_q;
  logic [tamrb_pkg::TIME_W-1:0]       quo_q;
  logic [DVW-1:0]                     rem_q;
  logic [DVW-1:0]                     dsr_q;
  logic [DVW:0]                       trial;
  logic [DVW:0]                       diff;
  logic                               fits;

  assign trial = {rem_q, quo_q[tamrb_pkg::TIME_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == tamrb_pkg::STEP_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - tamrb_pkg::STEP_W'(1);
        if (cnt_q == tamrb_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[tamrb_pkg::TIME_W-2:0], fits};
      rem_q <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

FILE: rtl/tamrb_store.sv
// tamrb_store: sample store with registered read and a zeroing sweep.
// The sweep runs after reset and on each clear request. Depends on tamrb_pkg.
`default_nettype none

module tamrb_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 clear_i,
  output logic                                busy_o,
  input  wire                                 we_i,
  input  wire  [AW-1:0]                       waddr_i,
  input  wire  [tamrb_pkg::SAMPLE_W-1:0]      wdata_i,
  input  wire  [AW-1:0]                       raddr_i,
  output logic [tamrb_pkg::SAMPLE_W-1:0]      rdata_o
);

  logic [tamrb_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic                           clr_q;
  logic [AW-1:0]                  clr_cnt_q;
  logic [tamrb_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_i) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign busy_o  = clr_q;
  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/timed_audio_mix_ring_buffer_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o op, has_audio, frame_time, sample_value,
//                                            sample_index, frame_samples
// out       output     out_valid_o/out_stall_i status, out_sample, current_time, frame_end
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. A timed push that mixes runs a 32-step offset division plus an
// AW-step head reduction on the shared serial divider; a head push and a readout run
// only the head reduction, and items rejected at decode run neither. AW = log2(RING_DEPTH).
// After reset and after every enable write the store is zeroed, with in_stall_o high.
// A finished result waits in the output register; the next item is taken meanwhile
// and only its own result waits on out_stall_i.
// Depends on tamrb_pkg, tamrb_div, tamrb_store.
`default_nettype none

module timed_audio_mix_ring_buffer_unit #(
  parameter int unsigned RING_DEPTH = tamrb_pkg::RING_DEPTH_DEF,
  parameter int unsigned MAX_FRAME  = tamrb_pkg::MAX_FRAME_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [tamrb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [tamrb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [1:0]                           op_i,
  input  wire                                  has_audio_i,
  input  wire  [31:0]                          frame_time_i,
  input  wire  signed [15:0]                   sample_value_i,
  input  wire  [9:0]                           sample_index_i,
  input  wire  [10:0]                          frame_samples_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [15:0]                   out_sample_o,
  output logic [31:0]                          current_time_o,
  output logic                                 frame_end_o
);

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned LW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned FW  = $clog2(MAX_FRAME + 1);
  localparam int unsigned EW  = (FW > 11) ? FW : 11;
  localparam int unsigned DVW = (LW > 10) ? LW : 10;
  localparam int unsigned PW  = 32 + FW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_DIVT = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIVH = 4'd5;
  localparam logic [3:0] S_ADDR = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  // configuration
  logic        enable_q;
  logic [10:0] spf_q;
  logic [12:0] blen_q;
  logic [9:0]  per_q;
  logic [31:0] start_q;
  logic        cfg_write;
  logic        clear_go;

  // state
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] head_q;
  logic [31:0]   time_q;
  logic [FW-1:0] cnt_q;

  // latched item
  logic [1:0]  op_q;
  logic        has_q;
  logic [31:0] ftime_q;
  logic [15:0] samp_q;
  logic [9:0]  idx_q;
  logic [10:0] fsamp_q;

  // datapath
  logic [PW-1:0] off_q;
  logic [AW-1:0] h_q;
  logic [AW-1:0] slot_q;
  logic [1:0]    res_status_q;
  logic [15:0]   res_sample_q;
  logic          res_fend_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic signed [15:0] out_sample_q;
  logic [31:0]        out_time_q;
  logic               out_fend_q;

  logic [LW-1:0] len_eff;
  logic [FW-1:0] spf_eff;
  logic [FW-1:0] fs_eff;
  logic [9:0]    per_eff;
  logic [10:0]   idx1;
  logic [EW-1:0] extent;
  logic [31:0]   delta;
  logic [PW:0]   reach;
  logic [LW:0]   pos;
  logic [AW-1:0] slot_d;
  logic [LW-1:0] head_inc;
  logic [FW:0]   cnt_inc;
  logic          accept;
  logic          out_load;
  logic          timed_go;
  logic          hmod_go;
  logic          far;

  tamrb_pkg::div_ctrl_t div_ctrl;
  tamrb_pkg::div_stat_t div_stat;
  logic [31:0]          div_dividend;
  logic [DVW-1:0]       div_divisor;
  logic [31:0]          div_quot;
  logic [DVW-1:0]       div_rem;

  logic        clr_busy;
  logic        mem_we;
  logic [15:0] mem_wdata;
  logic [15:0] mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign clear_go    = cfg_write && (cfg_index_i == tamrb_pkg::CFG_ENABLE);

  assign in_stall_o = (state_q != S_IDLE) || clr_busy || clear_go;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (blen_q == '0) begin
      len_eff = LW'(1);
    end else if (32'(blen_q) > 32'(RING_DEPTH)) begin
      len_eff = LW'(RING_DEPTH);
    end else begin
      len_eff = LW'(blen_q);
    end
    if (spf_q == '0) begin
      spf_eff = FW'(1);
    end else if (32'(spf_q) > 32'(MAX_FRAME)) begin
      spf_eff = FW'(MAX_FRAME);
    end else begin
      spf_eff = FW'(spf_q);
    end
    if (fsamp_q == '0) begin
      fs_eff = FW'(1);
    end else if (32'(fsamp_q) > 32'(MAX_FRAME)) begin
      fs_eff = FW'(MAX_FRAME);
    end else begin
      fs_eff = FW'(fsamp_q);
    end
  end

  assign per_eff  = (per_q == '0) ? 10'd1 : per_q;
  assign idx1     = {1'b0, idx_q} + 11'd1;
  assign extent   = (EW'(idx1) > EW'(fs_eff)) ? EW'(idx1) : EW'(fs_eff);
  assign delta    = ftime_q - time_q;
  assign reach    = (PW + 1)'(off_q) + (PW + 1)'(extent);
  assign far      = reach > (PW + 1)'(len_eff);
  assign pos      = (LW + 1)'(h_q) + (LW + 1)'(off_q[LW-1:0]) + (LW + 1)'(idx_q);
  assign slot_d   = (op_q == tamrb_pkg::OP_READ) ? h_q :
                    ((pos >= (LW + 1)'(len_eff)) ? AW'(pos - (LW + 1)'(len_eff)) : AW'(pos));
  assign head_inc = LW'(h_q) + LW'(1);
  assign cnt_inc  = (FW + 1)'(cnt_q) + (FW + 1)'(1);

  always_comb begin
    state_d  = state_q;
    timed_go = 1'b0;
    hmod_go  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DEC;
      end
      S_DEC: begin
        case (op_q)
          tamrb_pkg::OP_TIMED: begin
            if (delta[31] || !enable_q) begin
              state_d = S_RESP;
            end else begin
              timed_go = 1'b1;
              state_d  = S_DIVT;
            end
          end
          tamrb_pkg::OP_HEAD: begin
            state_d = (enable_q && has_q) ? S_CHK : S_RESP;
          end
          tamrb_pkg::OP_READ: begin
            if (enable_q) begin
              hmod_go = 1'b1;
              state_d = S_DIVH;
            end else begin
              state_d = S_RESP;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_DIVT: begin
        if (div_stat.done) state_d = S_MUL;
      end
      S_MUL: state_d = S_CHK;
      S_CHK: begin
        if (far || !has_q) begin
          state_d = S_RESP;
        end else begin
          hmod_go = 1'b1;
          state_d = S_DIVH;
        end
      end
      S_DIVH: begin
        if (div_stat.done) state_d = S_ADDR;
      end
      S_ADDR: state_d = S_RD;
      S_RD:   state_d = S_WR;
      S_WR:   state_d = S_RESP;
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  assign div_ctrl.start = timed_go || hmod_go;
  assign div_ctrl.steps = timed_go ? tamrb_pkg::STEP_W'(32) : tamrb_pkg::STEP_W'(AW);
  assign div_dividend   = timed_go ? delta : {head_q, {(32 - AW){1'b0}}};
  assign div_divisor    = timed_go ? DVW'(per_eff) : DVW'(len_eff);

  tamrb_div #(
    .DVW(DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign mem_we    = (state_q == S_WR);
  assign mem_wdata = (op_q == tamrb_pkg::OP_READ) ? 16'd0 : (mem_rdata + samp_q);

  tamrb_store #(
    .DEPTH(RING_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear_go),
    .busy_o  (clr_busy),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (mem_wdata),
    .raddr_i (slot_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      spf_q       <= 11'd80;
      blen_q      <= 13'd4096;
      per_q       <= 10'd10;
      start_q     <= '0;
      state_q     <= S_IDLE;
      head_q      <= '0;
      time_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write) begin
        case (cfg_index_i)
          tamrb_pkg::CFG_ENABLE: begin
            enable_q <= cfg_data_i[0];
            head_q   <= '0;
            cnt_q    <= '0;
            time_q   <= start_q;
          end
          tamrb_pkg::CFG_SPF:    spf_q   <= cfg_data_i[10:0];
          tamrb_pkg::CFG_BLEN:   blen_q  <= cfg_data_i[12:0];
          tamrb_pkg::CFG_PERIOD: per_q   <= cfg_data_i[9:0];
          tamrb_pkg::CFG_START:  start_q <= cfg_data_i;
          default: ;
        endcase
      end else if ((state_q == S_WR) && (op_q == tamrb_pkg::OP_READ)) begin
        head_q <= (head_inc >= len_eff) ? '0 : AW'(head_inc);
        if (cnt_inc >= (FW + 1)'(spf_eff)) begin
          cnt_q  <= '0;
          time_q <= time_q + 32'(per_q);
        end else begin
          cnt_q <= cnt_inc[FW-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      has_q   <= has_audio_i;
      ftime_q <= frame_time_i;
      samp_q  <= sample_value_i;
      idx_q   <= sample_index_i;
      fsamp_q <= frame_samples_i;
    end
    case (state_q)
      S_DEC: begin
        off_q        <= '0;
        res_sample_q <= '0;
        res_fend_q   <= 1'b0;
        if (op_q == tamrb_pkg::OP_TIMED && delta[31]) begin
          res_status_q <= tamrb_pkg::ST_LATE;
        end else if (!enable_q && (op_q inside {tamrb_pkg::OP_TIMED, tamrb_pkg::OP_HEAD,
                                                tamrb_pkg::OP_READ})) begin
          res_status_q <= tamrb_pkg::ST_DIS;
        end else begin
          res_status_q <= tamrb_pkg::ST_OK;
        end
      end
      S_MUL: off_q <= PW'(div_quot) * PW'(spf_eff);
      S_CHK: begin
        if (far) res_status_q <= tamrb_pkg::ST_FAR;
      end
      S_DIVH: begin
        if (div_stat.done) h_q <= div_rem[AW-1:0];
      end
      S_ADDR: slot_q <= slot_d;
      S_WR: begin
        if (op_q == tamrb_pkg::OP_READ) begin
          res_sample_q <= mem_rdata;
          res_fend_q   <= cnt_inc >= (FW + 1)'(spf_eff);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_q <= res_status_q;
      out_sample_q <= res_sample_q;
      out_time_q   <= time_q;
      out_fend_q   <= res_fend_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_sample_o   = out_sample_q;
  assign current_time_o = out_time_q;
  assign frame_end_o    = out_fend_q;

endmodule

`default_nettype wire

FILE: rtl/tamrb_chk.sv
// tamrb_chk: port-level checks on the mixing ring top level, bound to it below.
// Depends on tamrb_pkg and timed_audio_mix_ring_buffer_unit.
`default_nettype none

module tamrb_chk (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire [1:0]         status_o,
  input wire signed [15:0] out_sample_o,
  input wire [31:0]        current_time_o,
  input wire               frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_sample_o) && $stable(current_time_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tamrb_pkg::ST_OK) |-> (out_sample_o == 16'sd0) && !frame_end_o)
    else $error("rejected item carries sample data");

endmodule

bind timed_audio_mix_ring_buffer_unit tamrb_chk u_tamrb_chk (.*);

`default_nettype wire

FILE: tb/sv/mix_ring_checker.sv
`timescale 1ns / 1ps
// mix_ring_checker: watches the config, input and result channels of the timed audio
// mixing ring, predicts every result from its own copy of the ring and compares.
// Depends on tamrb_pkg; instantiated by timed_audio_mix_ring_buffer_unit_tb.
module mix_ring_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         op_i,
  input  logic               has_audio_i,
  input  logic [31:0]        frame_time_i,
  input  logic [15:0]        sample_value_i,
  input  logic [9:0]         sample_index_i,
  input  logic [10:0]        frame_samples_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic signed [15:0] out_sample_i,
  input  logic [31:0]        current_time_i,
  input  logic               frame_end_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output logic [31:0]        ring_time_o
);
  import tamrb_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_sample;
    logic [31:0] current_time;
    logic        frame_end;
  } mix_result_t;

  logic [15:0] mix_store_q [RING_DEPTH_DEF];
  logic [31:0] head_q, time_now_q, readout_cnt_q;
  logic [31:0] enable_q, spf_q, buf_len_q, period_q, start_q;
  mix_result_t owed_results [$];

  function automatic logic [31:0] clamp_cfg(logic [31:0] v, logic [31:0] hi);
    if (v == 0) return 32'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_ring();
    for (int i = 0; i < RING_DEPTH_DEF; i++) mix_store_q[i] = '0;
    head_q        = '0;
    readout_cnt_q = '0;
    time_now_q    = start_q;
  endtask

  task automatic mix_into_ring(input logic [63:0] offset, input logic [31:0] idx,
                               input logic [31:0] extent, input logic carry,
                               input logic [15:0] smp, output logic [1:0] st);
    logic [31:0] len;
    logic [63:0] pos;
    logic [31:0] slot;
    len = clamp_cfg(buf_len_q, RING_DEPTH_DEF);
    if (offset + {32'd0, extent} > {32'd0, len}) begin
      st = ST_FAR;
    end else begin
      st = ST_OK;
      if (carry) begin
        pos  = {32'd0, head_q % len} + offset + {32'd0, idx};
        slot = 32'(pos % {32'd0, len});
        mix_store_q[slot] = mix_store_q[slot] + smp;
      end
    end
  endtask

  task automatic predict_ring_step(input logic [1:0] op, input logic carry,
                                   input logic [31:0] ft, input logic [15:0] smp,
                                   input logic [9:0] sidx, input logic [10:0] fsamp,
                                   output mix_result_t r);
    logic [31:0] delta, per, fs, ext, len, h;
    logic [63:0] off;
    r  = '0;
    fs = clamp_cfg({21'd0, fsamp}, MAX_FRAME_DEF);
    ext = ({22'd0, sidx} + 32'd1 > fs) ? {22'd0, sidx} + 32'd1 : fs;
    case (op)
      OP_TIMED: begin
        delta = ft - time_now_q;
        if (delta[31]) begin
          r.status = ST_LATE;
        end else if (enable_q == 0) begin
          r.status = ST_DIS;
        end else begin
          per = (period_q == 0) ? 32'd1 : period_q;
          off = {32'd0, delta / per} * {32'd0, clamp_cfg(spf_q, MAX_FRAME_DEF)};
          mix_into_ring(off, {22'd0, sidx}, ext, carry, smp, r.status);
        end
      end
      OP_HEAD: begin
        if (enable_q == 0) r.status = ST_DIS;
        else if (carry) mix_into_ring(64'd0, {22'd0, sidx}, ext, 1'b1, smp, r.status);
      end
      OP_READ: begin
        if (enable_q == 0) begin
          r.status = ST_DIS;
        end else begin
          len = clamp_cfg(buf_len_q, RING_DEPTH_DEF);
          h = head_q % len;
          r.out_sample   = mix_store_q[h];
          mix_store_q[h] = '0;
          h = h + 1;
          if (h >= len) h = 0;
          head_q        = h;
          readout_cnt_q = readout_cnt_q + 1;
          if (readout_cnt_q >= clamp_cfg(spf_q, MAX_FRAME_DEF)) begin
            readout_cnt_q = 0;
            r.frame_end   = 1'b1;
            time_now_q    = time_now_q + period_q;
          end
        end
      end
      default: ;
    endcase
    r.current_time = time_now_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mix_result_t want;
    if (!rst_ni) begin
      enable_q  = 0;
      spf_q     = 80;
      buf_len_q = 4096;
      period_q  = 10;
      start_q   = 0;
      restart_ring();
      owed_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      ring_time_o  = time_now_q;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $error("result arrived with no item outstanding");
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (out_sample_i !== want.out_sample) begin
            $error("out_sample: expected %0d, got %0d", $signed(want.out_sample),
                   out_sample_i);
            fail_count_o++;
          end
          if (current_time_i !== want.current_time) begin
            $error("current_time: expected %h, got %h", want.current_time,
                   current_time_i);
            fail_count_o++;
          end
          if (frame_end_i !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ENABLE: begin
            enable_q = {31'd0, cfg_data_i[0]};
            restart_ring();
          end
          CFG_SPF:    spf_q     = cfg_data_i & 32'h7FF;
          CFG_BLEN:   buf_len_q = cfg_data_i & 32'h1FFF;
          CFG_PERIOD: period_q  = cfg_data_i & 32'h3FF;
          CFG_START:  start_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_ring_step(op_i, has_audio_i, frame_time_i, sample_value_i,
                          sample_index_i, frame_samples_i, want);
        owed_results.push_back(want);
      end
      pending_o   = owed_results.size();
      ring_time_o = time_now_q;
    end
  end

endmodule

FILE: tb/sv/timed_audio_mix_ring_buffer_unit_tb.sv
`timescale 1ns / 1ps
// timed_audio_mix_ring_buffer_unit_tb: drives directed and random pushes, readouts and
// ring settings into the mixing ring with random idling and backpressure.
// Depends on tamrb_pkg, the block and mix_ring_checker.
module timed_audio_mix_ring_buffer_unit_tb;
  import tamrb_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i     = '0;
  logic [31:0]        cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i            = '0;
  logic               has_audio_i     = 1'b0;
  logic [31:0]        frame_time_i    = '0;
  logic signed [15:0] sample_value_i  = '0;
  logic [9:0]         sample_index_i  = '0;
  logic [10:0]        frame_samples_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [1:0]         status_o;
  logic signed [15:0] out_sample_o;
  logic [31:0]        current_time_o;
  logic               frame_end_o;

  int unsigned fail_count, pending;
  logic [31:0] ring_time;

  int unsigned t_spf = 80, t_len = 4096, t_per = 10;
  int unsigned tx_gap_max = 15, rx_gap_max = 15, rx_hold_req = 0;

  timed_audio_mix_ring_buffer_unit dut (.*);

  mix_ring_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .has_audio_i, .frame_time_i,
    .sample_value_i, .sample_index_i, .frame_samples_i, .out_valid_i(out_valid_o),
    .out_stall_i, .status_i(status_o), .out_sample_i(out_sample_o),
    .current_time_i(current_time_o), .frame_end_i(frame_end_o),
    .fail_count_o(fail_count), .pending_o(pending), .ring_time_o(ring_time)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("** timed_audio_mix_ring_buffer_unit: FAILED **");
    $finish;
  end

  function automatic int unsigned clamp_eff(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] junk_bits(int unsigned w, logic junk);
    return junk ? ($urandom << w) : 32'd0;
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_item(input logic [1:0] op, input logic carry, input logic [31:0] ft,
                           input logic [15:0] smp, input logic [9:0] sidx,
                           input logic [10:0] fsamp);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    has_audio_i     <= carry;
    frame_time_i    <= ft;
    sample_value_i  <= smp;
    sample_index_i  <= sidx;
    frame_samples_i <= fsamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_ring(input int unsigned spf, input int unsigned blen,
                          input int unsigned per, input logic [31:0] start,
                          input logic en, input logic junk);
    wait_drained();
    cfg_write(CFG_SPF, spf | junk_bits(11, junk));
    cfg_write(CFG_BLEN, blen | junk_bits(13, junk));
    cfg_write(CFG_PERIOD, per | junk_bits(10, junk));
    cfg_write(CFG_START, start);
    cfg_write(CFG_ENABLE, {31'd0, en} | junk_bits(1, junk));
    t_spf = clamp_eff(spf & 'h7FF, MAX_FRAME_DEF);
    t_len = clamp_eff(blen & 'h1FFF, RING_DEPTH_DEF);
    t_per = clamp_eff(per & 'h3FF, 1024);
  endtask

  // mostly frames that land inside the ring and readouts, plus late, far and junk items
  task automatic rand_item();
    int unsigned kind, fs, si, ext, kmax, k;
    logic [31:0] ft;
    logic [15:0] smp;
    logic [1:0] op;
    logic carry;
    kind  = $urandom_range(0, 99);
    carry = ($urandom_range(0, 7) != 0);
    smp   = $urandom;
    fs    = t_spf;
    if ($urandom_range(0, 3) == 0) fs = $urandom_range(1, t_spf);
    si   = $urandom_range(0, t_spf - 1);
    ext  = (si + 1 > fs) ? si + 1 : fs;
    kmax = (t_len >= ext) ? (t_len - ext) / t_spf : 0;
    ft   = $urandom;
    if (kind < 40) begin
      op = OP_TIMED;
      k  = $urandom_range(0, kmax);
      ft = ring_time + k * t_per + $urandom_range(0, t_per - 1);
    end else if (kind < 55) begin
      op = OP_HEAD;
    end else if (kind < 85) begin
      op = OP_READ;
    end else if (kind < 91) begin
      op = OP_TIMED;
      ft = ring_time - $urandom_range(1, 32'h8000_0000);
    end else if (kind < 97) begin
      op = ($urandom_range(0, 1) == 0) ? OP_TIMED : OP_HEAD;
      fs = $urandom_range(0, 2047);
      si = $urandom_range(0, 1023);
    end else begin
      op = OP_NONE;
    end
    send_item(op, carry, ft, smp, si[9:0], fs[10:0]);
  endtask

  initial begin : rx_side
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = (rx_hold_req != 0) ? rx_hold_req : $urandom_range(0, rx_gap_max);
      rx_hold_req = 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned spf;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // block still disabled
    send_item(OP_TIMED, 1'b1, 32'd0, 16'h1234, 10'd0, 11'd1);
    send_item(OP_TIMED, 1'b1, 32'hFFFF_FFFF, 16'h1234, 10'd0, 11'd1);
    send_item(OP_HEAD, 1'b1, 32'd0, 16'h1234, 10'd0, 11'd1);
    send_item(OP_READ, 1'b0, 32'd0, 16'd0, 10'd0, 11'd1);
    send_item(OP_NONE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 11'h7FF);

    // small ring, time just below wrap
    set_ring(4, 16, 5, 32'hFFFF_FFF0, 1'b1, 1'b0);
    send_item(OP_TIMED, 1'b1, 32'hFFFF_FFF0, 16'h7FFF, 10'd0, 11'd4);
    send_item(OP_HEAD, 1'b1, 32'd0, 16'h0001, 10'd0, 11'd4);
    send_item(OP_TIMED, 1'b1, 32'h0000_0003, 16'h8000, 10'd3, 11'd4);
    send_item(OP_TIMED, 1'b1, 32'h0000_0003, 16'h0101, 10'd0, 11'd5);
    send_item(OP_TIMED, 1'b0, 32'h0000_0003, 16'h0101, 10'd0, 11'd5);
    send_item(OP_TIMED, 1'b0, 32'hFFFF_FFF0, 16'h0101, 10'd0, 11'd4);
    send_item(OP_HEAD, 1'b0, 32'd0, 16'h0202, 10'h3FF, 11'd1024);
    send_item(OP_HEAD, 1'b1, 32'd0, 16'h0202, 10'h3FF, 11'd0);
    send_item(OP_TIMED, 1'b1, 32'hFFFF_FFF0, 16'hFFFF, 10'd2, 11'd0);
    send_item(OP_TIMED, 1'b1, 32'hFFFF_FFEF, 16'h0303, 10'd0, 11'd1);
    send_item(OP_TIMED, 1'b1, 32'h0000_0005, 16'h0303, 10'd0, 11'd1);
    send_item(OP_HEAD, 1'b1, 32'd0, 16'h0404, 10'd3, 11'h7FF);
    repeat (8) send_item(OP_READ, 1'b1, $urandom, 16'd0, 10'd0, 11'd1);

    // default-like ring; long receiver hold, then a full drain mid-stream
    set_ring(80, 4096, 10, $urandom, 1'b1, 1'b0);
    for (int i = 0; i < 300; i++) begin
      if (i == 100) rx_hold_req = 400;
      if (i == 200) wait_drained();
      rand_item();
    end

    tx_gap_max = 0;
    rx_gap_max = 0;
    set_ring(1, 1, 1, 32'd0, 1'b1, 1'b0);
    repeat (120) rand_item();

    rx_gap_max = 15;
    set_ring(1024, 4096, 1000, 32'hFFFF_FF00, 1'b1, 1'b0);
    repeat (120) rand_item();

    tx_gap_max = 15;
    set_ring(2047, 8191, 0, $urandom, 1'b1, 1'b1);
    repeat (120) rand_item();

    set_ring(0, 0, 1023, $urandom, 1'b1, 1'b1);
    repeat (100) rand_item();

    // ring length and frame size changed under a live head
    set_ring(16, 256, 7, $urandom, 1'b1, 1'b0);
    repeat (100) rand_item();
    wait_drained();
    cfg_write(CFG_BLEN, 32'd48);
    t_len = 48;
    repeat (80) rand_item();
    wait_drained();
    cfg_write(CFG_SPF, 32'd8);
    t_spf = 8;
    repeat (60) rand_item();

    set_ring(16, 256, 7, $urandom, 1'b0, 1'b1);
    repeat (60) rand_item();

    repeat (7) begin
      spf = $urandom_range(1, 64);
      set_ring(spf, spf * $urandom_range(1, 4096 / spf), $urandom_range(1, 1023),
               $urandom, 1'b1, 1'b1);
      tx_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 15;
      rx_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 15;
      repeat (120) rand_item();
    end

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** timed_audio_mix_ring_buffer_unit: PASSED **");
    end else begin
      $display("** timed_audio_mix_ring_buffer_unit: FAILED **");
    end
    $finish;
  end

endmodule
